>>> rtl/core/abte_pkg.sv
// shared types, constants and tree-walk helpers for the array binary tree engine
// depends on nothing; used by abte_store and array_binary_tree_engine
package abte_pkg;

    // store geometry: a perfect tree of six levels fills the store exactly
    localparam int          ADDR_W     = 6;
    localparam int          DATA_W     = 32;
    localparam logic [6:0]  CAPACITY   = 7'd63;
    localparam logic [2:0]  TREE_DEPTH = 3'd6;
    localparam logic [3:0]  LEVEL_MAX  = 4'd15;

    // opcodes
    localparam logic [2:0] OP_SET_LEVEL = 3'd0;
    localparam logic [2:0] OP_WRITE     = 3'd1;
    localparam logic [2:0] OP_ADD_LEFT  = 3'd2;
    localparam logic [2:0] OP_ADD_RIGHT = 3'd3;
    localparam logic [2:0] OP_PRE       = 3'd4;
    localparam logic [2:0] OP_IN        = 3'd5;
    localparam logic [2:0] OP_POST      = 3'd6;

    // status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_RANGE      = 3'd1;
    localparam logic [2:0] ST_EMPTY      = 3'd2;
    localparam logic [2:0] ST_BAD_PARENT = 3'd3;
    localparam logic [2:0] ST_NO_EXTEND  = 3'd4;

    typedef struct packed {
        logic [2:0]               opcode;
        logic [6:0]               index;
        logic signed [DATA_W-1:0] value;
    } t_in_req;

    typedef struct packed {
        logic [ADDR_W-1:0]        node_index;
        logic signed [DATA_W-1:0] node_value;
        logic [2:0]               status;
        logic                     last;
    } t_out_rsp;

    // position of the highest set bit plus one
    function automatic logic [2:0] bit_len(input logic [6:0] x);
        logic [2:0] len;
        len = 3'd0;
        for (int i = 0; i < 7; i++) begin
            if (x[i]) len = 3'(i + 1);
        end
        return len;
    endfunction

    // number of consecutive ones from the lsb
    function automatic logic [2:0] trail_ones(input logic [ADDR_W-1:0] h);
        logic [2:0] cnt;
        logic       run;
        cnt = 3'd0;
        run = 1'b1;
        for (int i = 0; i < ADDR_W; i++) begin
            if (run && h[i]) cnt = cnt + 3'd1;
            else             run = 1'b0;
        end
        return cnt;
    endfunction

    // used slots for a given level
    function automatic logic [ADDR_W-1:0] extent_of(input logic [3:0] level);
        logic [ADDR_W-1:0] e;
        if (level >= {1'b0, TREE_DEPTH}) e = CAPACITY[ADDR_W-1:0];
        else                              e = (6'd1 << level) - 6'd1;
        return e;
    endfunction

    // depth of the perfect tree actually in use
    function automatic logic [2:0] depth_of(input logic [3:0] level);
        logic [2:0] d;
        if (level >= {1'b0, TREE_DEPTH}) d = TREE_DEPTH;
        else                              d = level[2:0];
        return d;
    endfunction

    // level after extending so that 0-based index i is covered
    function automatic logic [3:0] grow_level(input logic [3:0] level,
                                              input logic [ADDR_W-1:0] i);
        logic [3:0] base;
        logic [3:0] need;
        base = (level == 4'd0) ? 4'd1 : level;
        need = {1'b0, bit_len({1'b0, i} + 7'd1)};
        if (base >= {1'b0, TREE_DEPTH}) return base;
        return (need > base) ? need : base;
    endfunction

    // leftmost leaf under 1-based node h in a tree of depth d
    function automatic logic [ADDR_W-1:0] leftmost_leaf(input logic [6:0] h,
                                                        input logic [2:0] d);
        logic [2:0] sh;
        logic [6:0] w;
        sh = d - bit_len(h);
        w  = h << sh;
        return w[ADDR_W-1:0];
    endfunction

    // successors over 1-based heap numbers (children 2h, 2h+1)
    function automatic logic [ADDR_W-1:0] pre_next(input logic [ADDR_W-1:0] h,
                                                   input logic [2:0] d);
        logic [ADDR_W-1:0] up;
        up = h >> trail_ones(h);
        if (bit_len({1'b0, h}) < d) return {h[ADDR_W-2:0], 1'b0};
        return up + 6'd1;
    endfunction

    function automatic logic [ADDR_W-1:0] in_next(input logic [ADDR_W-1:0] h,
                                                  input logic [2:0] d);
        logic [ADDR_W-1:0] up;
        up = h >> trail_ones(h);
        if (bit_len({1'b0, h}) < d) return leftmost_leaf({h, 1'b1}, d);
        return up >> 1;
    endfunction

    function automatic logic [ADDR_W-1:0] post_next(input logic [ADDR_W-1:0] h,
                                                    input logic [2:0] d);
        if (!h[0]) return leftmost_leaf({1'b0, h} + 7'd1, d);
        return h >> 1;
    endfunction

    // first node of a walk
    function automatic logic [ADDR_W-1:0] walk_start(input logic [2:0] op,
                                                     input logic [2:0] d);
        if (op == OP_PRE) return 6'd1;
        return 6'd1 << (d - 3'd1);
    endfunction

endpackage

>>> rtl/core/abte_store.sv
// node store: 63 x 32 synchronous memory, one write and one registered read port
// per-entry valid bits make never-written entries read as zero after reset
// depends on abte_pkg
module abte_store (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_wr_en,
    input  logic [abte_pkg::ADDR_W-1:0]        i_wr_addr,
    input  logic [abte_pkg::DATA_W-1:0]        i_wr_data,
    input  logic                               i_rd_en,
    input  logic [abte_pkg::ADDR_W-1:0]        i_rd_addr,
    output logic [abte_pkg::DATA_W-1:0]        o_rd_data
);

    logic [abte_pkg::DATA_W-1:0]   r_mem [0:int'(abte_pkg::CAPACITY)-1];
    logic [int'(abte_pkg::CAPACITY)-1:0] r_valid;
    logic [abte_pkg::DATA_W-1:0]   r_rd_data;
    logic                          r_rd_valid;

    // memory array, write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // valid bits stand in for clearing the array
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

>>> rtl/core/array_binary_tree_engine.sv
// Binary tree kept heap-style in a 63-entry store (children of p at 2p+1 and 2p+2).
// Set level, write node and add child each give one result.
// A traversal of n used nodes (n = 1, 3, 7, 15, 31 or 63) first launches
// the store read of its first node and then gives one result per cycle while
// the result side does not stall, paced by the single read port of the store.
// The store needs no clearing pass after reset. A new request is taken only
// while no traversal runs and the result register is free or being emptied.
// depends on abte_pkg and abte_store
module array_binary_tree_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  abte_pkg::t_in_req  i_in_req,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output abte_pkg::t_out_rsp o_out_rsp
);

    typedef enum logic {
        S_IDLE,
        S_WALK
    } t_state;

    t_state                        r_state, n_state;
    logic [3:0]                    r_level, n_level;
    logic [abte_pkg::ADDR_W-1:0]   r_cur, n_cur;
    logic [abte_pkg::ADDR_W-1:0]   r_k, n_k;
    logic [2:0]                    r_order, n_order;
    logic [2:0]                    r_depth, n_depth;
    logic                          r_out_valid, n_out_valid;
    abte_pkg::t_out_rsp            r_out, n_out;

    logic                          slot_free;
    logic                          accept;
    logic [abte_pkg::ADDR_W-1:0]   count;
    logic [6:0]                    child;
    logic [abte_pkg::ADDR_W-1:0]   walk_next;
    logic                          wr_en;
    logic [abte_pkg::ADDR_W-1:0]   wr_addr;
    logic                          rd_en;
    logic [abte_pkg::ADDR_W-1:0]   rd_addr;
    logic [abte_pkg::DATA_W-1:0]   rd_data;

    // handshake
    assign slot_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || !slot_free;
    assign accept     = i_in_valid && !o_in_stall;
    assign count      = abte_pkg::extent_of(r_level);
    assign child      = {i_in_req.index[abte_pkg::ADDR_W-1:0], 1'b0}
                        + ((i_in_req.opcode == abte_pkg::OP_ADD_LEFT) ? 7'd1 : 7'd2);

    // successor of the current node for the running order
    always_comb begin
        case (r_order)
            abte_pkg::OP_PRE:  walk_next = abte_pkg::pre_next(r_cur, r_depth);
            abte_pkg::OP_IN:   walk_next = abte_pkg::in_next(r_cur, r_depth);
            abte_pkg::OP_POST: walk_next = abte_pkg::post_next(r_cur, r_depth);
            default:           walk_next = r_cur;
        endcase
    end

    // request decode and walk sequencing
    always_comb begin
        n_state     = r_state;
        n_level     = r_level;
        n_cur       = r_cur;
        n_k         = r_k;
        n_order     = r_order;
        n_depth     = r_depth;
        n_out_valid = slot_free ? 1'b0 : r_out_valid;
        n_out       = r_out;
        wr_en       = 1'b0;
        wr_addr     = '0;
        rd_en       = 1'b0;
        rd_addr     = r_cur - 6'd1;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_out.node_index = '0;
                    n_out.node_value = '0;
                    n_out.status     = abte_pkg::ST_OK;
                    n_out.last       = 1'b1;
                    case (i_in_req.opcode)
                        abte_pkg::OP_SET_LEVEL: begin
                            n_out_valid = 1'b1;
                            n_level = (i_in_req.index > {3'd0, abte_pkg::LEVEL_MAX})
                                      ? abte_pkg::LEVEL_MAX : i_in_req.index[3:0];
                        end
                        abte_pkg::OP_WRITE: begin
                            n_out_valid = 1'b1;
                            if (i_in_req.index >= abte_pkg::CAPACITY) begin
                                n_out.status = abte_pkg::ST_RANGE;
                            end else if (count == '0) begin
                                // empty tree: root is created, index ignored
                                n_level          = 4'd1;
                                wr_en            = 1'b1;
                                wr_addr          = '0;
                                n_out.node_value = i_in_req.value;
                            end else begin
                                n_level = abte_pkg::grow_level(r_level,
                                              i_in_req.index[abte_pkg::ADDR_W-1:0]);
                                wr_en            = 1'b1;
                                wr_addr          = i_in_req.index[abte_pkg::ADDR_W-1:0];
                                n_out.node_index = i_in_req.index[abte_pkg::ADDR_W-1:0];
                                n_out.node_value = i_in_req.value;
                            end
                        end
                        abte_pkg::OP_ADD_LEFT, abte_pkg::OP_ADD_RIGHT: begin
                            n_out_valid = 1'b1;
                            if (count == '0) begin
                                n_out.status = abte_pkg::ST_EMPTY;
                            end else if (i_in_req.index >= {1'b0, count}) begin
                                n_out.status = abte_pkg::ST_BAD_PARENT;
                            end else if (child >= abte_pkg::CAPACITY) begin
                                n_out.status = abte_pkg::ST_NO_EXTEND;
                            end else begin
                                n_level = abte_pkg::grow_level(r_level,
                                              child[abte_pkg::ADDR_W-1:0]);
                                wr_en            = 1'b1;
                                wr_addr          = child[abte_pkg::ADDR_W-1:0];
                                n_out.node_index = child[abte_pkg::ADDR_W-1:0];
                                n_out.node_value = i_in_req.value;
                            end
                        end
                        abte_pkg::OP_PRE, abte_pkg::OP_IN, abte_pkg::OP_POST: begin
                            if (count == '0) begin
                                n_out_valid  = 1'b1;
                                n_out.status = abte_pkg::ST_EMPTY;
                            end else begin
                                // launch the read of the first node
                                n_depth = abte_pkg::depth_of(r_level);
                                n_order = i_in_req.opcode;
                                n_cur   = abte_pkg::walk_start(i_in_req.opcode,
                                              abte_pkg::depth_of(r_level));
                                n_k     = '0;
                                rd_en   = 1'b1;
                                rd_addr = n_cur - 6'd1;
                                n_state = S_WALK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_WALK: begin
                if (slot_free) begin
                    // emit the node already read from the store and fetch the next one
                    n_out_valid      = 1'b1;
                    n_out.node_index = r_cur - 6'd1;
                    n_out.node_value = rd_data;
                    n_out.status     = abte_pkg::ST_OK;
                    n_out.last       = (r_k == count - 6'd1);
                    if (r_k == count - 6'd1) begin
                        n_state = S_IDLE;
                    end else begin
                        n_cur   = walk_next;
                        n_k     = r_k + 6'd1;
                        rd_en   = 1'b1;
                        rd_addr = walk_next - 6'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_level     <= 4'd0;
            r_out_valid <= 1'b0;
            r_cur       <= '0;
            r_k         <= '0;
            r_order     <= abte_pkg::OP_PRE;
            r_depth     <= '0;
        end else begin
            r_state     <= n_state;
            r_level     <= n_level;
            r_out_valid <= n_out_valid;
            r_cur       <= n_cur;
            r_k         <= n_k;
            r_order     <= n_order;
            r_depth     <= n_depth;
        end
        r_out <= n_out;
    end

    abte_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_in_req.value),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

endmodule
